// ===== sv/spl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spotlight Phong shading package
// Shared types, register map and arithmetic constants of the shading unit.
// ----------------------------------------------------------------------------
package spl_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int EXP_BITS_DEFAULT   = 8;
    localparam int ONE14              = 16384;
    localparam int R_BITS             = 17;
    localparam int DIV_STEPS          = 15;
    localparam int ADDR_W             = 5;
    localparam int DATA_W             = 64;

    localparam logic [1:0] REG_LIGHT_POSITION  = 2'd0;
    localparam logic [1:0] REG_LIGHT_AXIS      = 2'd1;
    localparam logic [1:0] REG_CUTOFF_COSINE   = 2'd2;
    localparam logic [1:0] REG_LIGHT_INTENSITY = 2'd3;

    typedef struct packed {
        logic [47:0] surface_point;
        logic [47:0] surface_normal;
        logic [47:0] view_direction;
        logic [47:0] diffuse_coeff;
        logic [7:0]  shininess_exp;
    } in_item_t;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic        in_cone;
    } out_item_t;

    function automatic int unit_latency(input int w);
        return w + 20;
    endfunction

endpackage

// ===== sv/spl_delay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spotlight shading delay line
// Fixed-length shift register that keeps side data in step with the pipeline.
// ----------------------------------------------------------------------------
module spl_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                line_reg[k] <= '0;
            end
        end
        else
        begin
            line_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

// ===== sv/spl_unitize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spotlight shading vector normaliser
// Pipelined square root and division giving a Q1.14 unit vector and a flag
// for the zero vector.
// ----------------------------------------------------------------------------
module spl_unitize #(
    parameter int W = 17
) (
    input  logic                clk,
    input  logic signed [W-1:0] vec [3],
    output logic signed [15:0]  unit [3],
    output logic                zero
);
    import spl_pkg::*;

    localparam int NS  = W + 1;
    localparam int XW  = 2 * NS;
    localparam int RMW = NS + 2;
    localparam int QW  = DIV_STEPS;

    logic [W-1:0]     mag_reg [3];
    logic [2:0]       sgn_reg;
    logic [2*W-1:0]   sq_reg [3];
    logic [W-1:0]     mag_sq_reg [3];
    logic [2:0]       sgn_sq_reg;
    logic [XW-1:0]    sum_reg;
    logic [W-1:0]     mag_sum_reg [3];
    logic [2:0]       sgn_sum_reg;

    logic [XW-1:0]    x_reg [NS];
    logic [XW-1:0]    x_next [NS];
    logic [RMW-1:0]   rem_reg [NS];
    logic [RMW-1:0]   rem_next [NS];
    logic [NS-1:0]    root_reg [NS];
    logic [NS-1:0]    root_next [NS];
    logic [W-1:0]     mag_rt_reg [NS][3];
    logic [W-1:0]     mag_rt_next [NS][3];
    logic [2:0]       sgn_rt_reg [NS];
    logic [2:0]       sgn_rt_next [NS];

    logic [NS-1:0]    drem_reg [DIV_STEPS][3];
    logic [NS-1:0]    drem_next [DIV_STEPS][3];
    logic [QW-1:0]    q_reg [DIV_STEPS][3];
    logic [QW-1:0]    q_next [DIV_STEPS][3];
    logic [NS-1:0]    dn_reg [DIV_STEPS];
    logic [NS-1:0]    dn_next [DIV_STEPS];
    logic [2:0]       dsgn_reg [DIV_STEPS];
    logic [2:0]       dsgn_next [DIV_STEPS];

    logic signed [15:0] unit_reg [3];
    logic               zero_reg;

    always_comb
    begin
        logic [XW-1:0]  xin;
        logic [RMW-1:0] rin;
        logic [NS-1:0]  rtin;
        logic [RMW+1:0] remsh;
        logic [RMW+1:0] trial;
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                xin            = sum_reg;
                rin            = '0;
                rtin           = '0;
                mag_rt_next[k] = mag_sum_reg;
                sgn_rt_next[k] = sgn_sum_reg;
            end
            else
            begin
                xin            = x_reg[k-1];
                rin            = rem_reg[k-1];
                rtin           = root_reg[k-1];
                mag_rt_next[k] = mag_rt_reg[k-1];
                sgn_rt_next[k] = sgn_rt_reg[k-1];
            end
            remsh = {rin, xin[XW-1 -: 2]};
            trial = (RMW+2)'({rtin, 2'b01});
            if (remsh >= trial)
            begin
                rem_next[k]  = RMW'(remsh - trial);
                root_next[k] = {rtin[NS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = RMW'(remsh);
                root_next[k] = {rtin[NS-2:0], 1'b0};
            end
            x_next[k] = xin << 2;
        end
    end

    always_comb
    begin
        logic [NS-1:0] rin;
        logic [NS-1:0] nin;
        logic [QW-1:0] qin;
        logic          bdn;
        logic [NS:0]   sh;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            if (j == 0)
            begin
                dn_next[j]   = root_reg[NS-1];
                dsgn_next[j] = sgn_rt_reg[NS-1];
            end
            else
            begin
                dn_next[j]   = dn_reg[j-1];
                dsgn_next[j] = dsgn_reg[j-1];
            end
            nin = dn_next[j];
            for (int i = 0; i < 3; i++)
            begin
                if (j == 0)
                begin
                    rin = NS'(mag_rt_reg[NS-1][i] >> 1);
                    bdn = mag_rt_reg[NS-1][i][0];
                    qin = '0;
                end
                else
                begin
                    rin = drem_reg[j-1][i];
                    bdn = 1'b0;
                    qin = q_reg[j-1][i];
                end
                sh = {rin, bdn};
                if (sh >= {1'b0, nin})
                begin
                    drem_next[j][i] = NS'(sh - {1'b0, nin});
                    q_next[j][i]    = {qin[QW-2:0], 1'b1};
                end
                else
                begin
                    drem_next[j][i] = NS'(sh);
                    q_next[j][i]    = {qin[QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_reg[i]     <= vec[i][W-1] ? W'(-vec[i]) : W'(vec[i]);
            sgn_reg[i]     <= vec[i][W-1];
            sq_reg[i]      <= mag_reg[i] * mag_reg[i];
            mag_sq_reg[i]  <= mag_reg[i];
            mag_sum_reg[i] <= mag_sq_reg[i];
        end
        sgn_sq_reg  <= sgn_reg;
        sgn_sum_reg <= sgn_sq_reg;
        sum_reg     <= XW'(sq_reg[0]) + XW'(sq_reg[1]) + XW'(sq_reg[2]);
        x_reg       <= x_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        mag_rt_reg  <= mag_rt_next;
        sgn_rt_reg  <= sgn_rt_next;
        drem_reg    <= drem_next;
        q_reg       <= q_next;
        dn_reg      <= dn_next;
        dsgn_reg    <= dsgn_next;
        for (int i = 0; i < 3; i++)
        begin
            unit_reg[i] <= dsgn_reg[DIV_STEPS-1][i] ? -signed'(16'(q_reg[DIV_STEPS-1][i]))
                                                    : signed'(16'(q_reg[DIV_STEPS-1][i]));
        end
        zero_reg <= (dn_reg[DIV_STEPS-1] == '0);
    end

    assign unit = unit_reg;
    assign zero = zero_reg;

endmodule

// ===== sv/spl_power.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spotlight shading specular power
// Square-and-multiply over the exponent bits, one bit per pipeline stage.
// ----------------------------------------------------------------------------
module spl_power #(
    parameter int EXP_BITS = 8
) (
    input  logic                clk,
    input  logic [14:0]         base,
    input  logic [EXP_BITS-1:0] expo,
    output logic [14:0]         spec
);
    import spl_pkg::*;

    logic [14:0]         r_reg [EXP_BITS];
    logic [14:0]         r_next [EXP_BITS];
    logic [14:0]         b_reg [EXP_BITS];
    logic [14:0]         b_next [EXP_BITS];
    logic [EXP_BITS-1:0] e_reg [EXP_BITS];
    logic [EXP_BITS-1:0] e_next [EXP_BITS];

    always_comb
    begin
        logic [14:0] rin;
        logic [14:0] bin;
        logic [29:0] pr;
        logic [29:0] pb;
        for (int k = 0; k < EXP_BITS; k++)
        begin
            if (k == 0)
            begin
                rin       = 15'(ONE14);
                bin       = base;
                e_next[k] = expo;
            end
            else
            begin
                rin       = r_reg[k-1];
                bin       = b_reg[k-1];
                e_next[k] = e_reg[k-1];
            end
            pr        = rin * bin;
            pb        = bin * bin;
            r_next[k] = e_next[k][k] ? 15'(pr >> 14) : rin;
            b_next[k] = 15'(pb >> 14);
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        b_reg <= b_next;
        e_reg <= e_next;
    end

    assign spec = r_reg[EXP_BITS-1];

endmodule

// ===== sv/spotlight_phong_shading_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spotlight Phong shading unit
// Shades a surface point lit by a spotlight: cone test, two-sided diffuse and
// Phong specular, saturated to Q8.8.
// ----------------------------------------------------------------------------
// The latency is set by the two pipelined normalisers in series, one square-root
// bit pair and one quotient bit per stage, and by the power pipeline, one
// exponent bit per stage. One item is taken every cycle; busy stays low and the
// done strobe cannot be held off. Reset clears the configuration registers, the
// delay lines and the done strobe, and discards every item in flight.
// ----------------------------------------------------------------------------
module spotlight_phong_shading_unit #(
    parameter int COORD_BITS = spl_pkg::COORD_BITS_DEFAULT,
    parameter int EXP_BITS   = spl_pkg::EXP_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  spl_pkg::in_item_t           item,
    output logic                        done,
    output spl_pkg::out_item_t          result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spl_pkg::ADDR_W-1:0]  paddr,
    input  logic [spl_pkg::DATA_W-1:0]  pwdata,
    output logic [spl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import spl_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int PW   = 3 * C;
    localparam int UW1  = C + 1;
    localparam int L1   = unit_latency(UW1);
    localparam int L2   = unit_latency(R_BITS);
    localparam int T_RV = L1 + L2 + 5;
    localparam int T_S  = T_RV + EXP_BITS;
    localparam int LAT  = T_S + 3;

    function automatic logic signed [15:0] dot_clamp(input logic signed [33:0] s);
        logic signed [33:0] f;
        f = s >>> 14;
        if (f > ONE14)
        begin
            return 16'(ONE14);
        end
        if (f < -ONE14)
        begin
            return 16'(-ONE14);
        end
        return 16'(f);
    endfunction

    logic [47:0]        lp_reg;
    logic [47:0]        la_reg;
    logic signed [15:0] cutoff_reg;
    logic [47:0]        li_reg;

    logic accept;
    logic cfg_write;

    assign busy      = 1'b0;
    assign pready    = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg     <= '0;
            la_reg     <= '0;
            cutoff_reg <= '0;
            li_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:3])
                REG_LIGHT_POSITION:  lp_reg     <= pwdata[47:0];
                REG_LIGHT_AXIS:      la_reg     <= pwdata[47:0];
                REG_CUTOFF_COSINE:   cutoff_reg <= pwdata[15:0];
                REG_LIGHT_INTENSITY: li_reg     <= pwdata[47:0];
                default:             lp_reg     <= lp_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_LIGHT_POSITION:  prdata = {16'b0, lp_reg};
            REG_LIGHT_AXIS:      prdata = {16'b0, la_reg};
            REG_CUTOFF_COSINE:   prdata = {48'b0, cutoff_reg};
            REG_LIGHT_INTENSITY: prdata = {16'b0, li_reg};
            default:             prdata = '0;
        endcase
    end

    logic [PW+47:0] pt_pad;
    logic [PW+47:0] lp_pad;
    logic [PW+47:0] la_pad;
    logic [PW+47:0] nr_pad;
    logic [PW+47:0] vw_pad;

    assign pt_pad = {{PW{1'b0}}, item.surface_point};
    assign lp_pad = {{PW{1'b0}}, lp_reg};
    assign la_pad = {{PW{1'b0}}, la_reg};
    assign nr_pad = {{PW{1'b0}}, item.surface_normal};
    assign vw_pad = {{PW{1'b0}}, item.view_direction};

    logic signed [UW1-1:0] d_vec [3];
    logic signed [UW1-1:0] a_vec [3];
    logic signed [UW1-1:0] n_vec [3];
    logic signed [UW1-1:0] v_vec [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_vec[i] = UW1'(signed'(pt_pad[i*C +: C])) - UW1'(signed'(lp_pad[i*C +: C]));
            a_vec[i] = UW1'(signed'(la_pad[i*C +: C]));
            n_vec[i] = UW1'(signed'(nr_pad[i*C +: C]));
            v_vec[i] = UW1'(signed'(vw_pad[i*C +: C]));
        end
    end

    logic signed [15:0] dn [3];
    logic signed [15:0] an [3];
    logic signed [15:0] nn [3];
    logic signed [15:0] vn [3];
    logic               d_zero;
    logic               a_zero;
    logic               n_zero;
    logic               v_zero;

    spl_unitize #(.W(UW1)) u_unit_d (.clk(clk), .vec(d_vec), .unit(dn), .zero(d_zero));
    spl_unitize #(.W(UW1)) u_unit_a (.clk(clk), .vec(a_vec), .unit(an), .zero(a_zero));
    spl_unitize #(.W(UW1)) u_unit_n (.clk(clk), .vec(n_vec), .unit(nn), .zero(n_zero));
    spl_unitize #(.W(UW1)) u_unit_v (.clk(clk), .vec(v_vec), .unit(vn), .zero(v_zero));

    logic signed [31:0] psa_reg [3];
    logic signed [31:0] pnl_reg [3];
    logic signed [15:0] nn_a_reg [3];
    logic signed [15:0] l_a_reg [3];
    logic               zero_a_reg;
    logic signed [15:0] nl_b_reg;
    logic               lit_b_reg;
    logic signed [15:0] nn_b_reg [3];
    logic signed [15:0] l_b_reg [3];
    logic signed [31:0] rprod_c_reg [3];
    logic signed [15:0] l_c_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            psa_reg[i]     <= dn[i] * an[i];
            pnl_reg[i]     <= nn[i] * (-dn[i]);
            nn_a_reg[i]    <= nn[i];
            l_a_reg[i]     <= -dn[i];
            nn_b_reg[i]    <= nn_a_reg[i];
            l_b_reg[i]     <= l_a_reg[i];
            rprod_c_reg[i] <= nl_b_reg * nn_b_reg[i];
            l_c_reg[i]     <= l_b_reg[i];
        end
        zero_a_reg <= d_zero || a_zero || n_zero || v_zero;
        nl_b_reg   <= dot_clamp(34'(pnl_reg[0]) + 34'(pnl_reg[1]) + 34'(pnl_reg[2]));
        lit_b_reg  <= !zero_a_reg
                      && (dot_clamp(34'(psa_reg[0]) + 34'(psa_reg[1]) + 34'(psa_reg[2]))
                          >= cutoff_reg);
    end

    logic signed [R_BITS-1:0] r_vec [3];
    logic signed [15:0]       rn [3];
    logic                     r_zero;

    always_comb
    begin
        logic signed [31:0] rs;
        for (int i = 0; i < 3; i++)
        begin
            rs       = rprod_c_reg[i] >>> 13;
            r_vec[i] = R_BITS'(rs) - R_BITS'(l_c_reg[i]);
        end
    end

    spl_unitize #(.W(R_BITS)) u_unit_r (.clk(clk), .vec(r_vec), .unit(rn), .zero(r_zero));

    logic [47:0] vn_d;
    logic [16:0] nl_lit_d;
    logic [7:0]  shin_d;
    logic [47:0] kd_d;
    logic        valid_d;

    spl_delay #(.WIDTH(48), .DEPTH(L2 + 3)) u_dly_vn (
        .clk(clk), .rst_n(rst_n), .din({vn[2], vn[1], vn[0]}), .dout(vn_d)
    );
    spl_delay #(.WIDTH(17), .DEPTH(L2 + 3 + EXP_BITS)) u_dly_nl (
        .clk(clk), .rst_n(rst_n), .din({lit_b_reg, nl_b_reg}), .dout(nl_lit_d)
    );
    spl_delay #(.WIDTH(8), .DEPTH(T_RV)) u_dly_shin (
        .clk(clk), .rst_n(rst_n), .din(item.shininess_exp), .dout(shin_d)
    );
    spl_delay #(.WIDTH(48), .DEPTH(T_S)) u_dly_kd (
        .clk(clk), .rst_n(rst_n), .din(item.diffuse_coeff), .dout(kd_d)
    );
    spl_delay #(.WIDTH(1), .DEPTH(LAT - 1)) u_dly_valid (
        .clk(clk), .rst_n(rst_n), .din(accept), .dout(valid_d)
    );

    logic signed [31:0] prv_reg [3];
    logic               rzero_e_reg;
    logic [14:0]        rv_reg;
    logic [14:0]        spec;

    always_ff @(posedge clk)
    begin
        logic signed [15:0] rvd;
        for (int i = 0; i < 3; i++)
        begin
            prv_reg[i] <= rn[i] * signed'(vn_d[16*i +: 16]);
        end
        rzero_e_reg <= r_zero;
        rvd         = dot_clamp(34'(prv_reg[0]) + 34'(prv_reg[1]) + 34'(prv_reg[2]));
        rv_reg      <= (rzero_e_reg || rvd < 0) ? '0 : 15'(rvd);
    end

    spl_power #(.EXP_BITS(EXP_BITS)) u_power (
        .clk(clk), .base(rv_reg), .expo(EXP_BITS'(shin_d)), .spec(spec)
    );

    logic [15:0] weight_reg;
    logic [31:0] kit_reg [3];
    logic        lit_w1_reg;
    logic [47:0] prod_reg [3];
    logic        lit_w2_reg;
    out_item_t   result_reg;
    logic        done_reg;

    always_ff @(posedge clk)
    begin
        logic signed [15:0] nls;
        logic [18:0]        c;
        nls        = signed'(nl_lit_d[15:0]);
        weight_reg <= (nls < 0 ? 16'(-nls) : 16'(nls)) + 16'(spec);
        lit_w1_reg <= nl_lit_d[16];
        lit_w2_reg <= lit_w1_reg;
        for (int i = 0; i < 3; i++)
        begin
            kit_reg[i]  <= kd_d[16*i +: 16] * li_reg[16*i +: 16];
            prod_reg[i] <= kit_reg[i] * weight_reg;
        end
        c = prod_reg[0][47:29];
        result_reg.red_out   <= !lit_w2_reg ? '0 : (c > 19'hFFFF ? 16'hFFFF : c[15:0]);
        c = prod_reg[1][47:29];
        result_reg.green_out <= !lit_w2_reg ? '0 : (c > 19'hFFFF ? 16'hFFFF : c[15:0]);
        c = prod_reg[2][47:29];
        result_reg.blue_out  <= !lit_w2_reg ? '0 : (c > 19'hFFFF ? 16'hFFFF : c[15:0]);
        result_reg.in_cone   <= lit_w2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_d;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("transfer did not complete after the pipeline latency");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching input transfer");

    a_dark: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.in_cone |->
            result.red_out == '0 && result.green_out == '0 && result.blue_out == '0)
        else $error("colour outside the cone is not black");

endmodule

// ===== tb/spotlight_phong_shading_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spotlight Phong shading unit testbench
// Drives shading transfers through the command port and registers through the
// APB port. A built-in predictor works out every expected colour and cone flag,
// and a monitor compares each result transfer with the oldest expectation.
// ----------------------------------------------------------------------------
module spotlight_phong_shading_unit_tb;
    import spl_pkg::*;

    localparam int CB      = 16;
    localparam int EB      = 8;
    localparam int LAT     = CB + EB + 66;
    localparam int LIMIT   = 400000;
    localparam int NRAND   = 1530;
    localparam longint U14 = 16384;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    in_item_t         item;
    logic             done;
    out_item_t        result;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic             pready;

    spotlight_phong_shading_unit #(.COORD_BITS(CB), .EXP_BITS(EB)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    logic [47:0] lt_pos;
    logic [47:0] lt_axis;
    logic signed [15:0] lt_cut;
    logic [47:0] lt_int;

    in_item_t  pending_q[$];
    out_item_t shade_q[$];
    int        mismatches;
    int        cycles;
    bit        quiet_run;
    bit        hold_send;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint comp(input logic [47:0] w, input int i);
        logic signed [15:0] c;
        c = w[16*i +: 16];
        return longint'(c);
    endfunction

    function automatic longint fshift(input longint v, input int k);
        return v >>> k;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint root_floor(input longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > x)
            b = b >>> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic bit to_unit(input longint v[3], output longint o[3]);
        longint s;
        longint n;
        s = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        n = root_floor(s);
        if (n == 0)
        begin
            o = '{0, 0, 0};
            return 1'b0;
        end
        for (int i = 0; i < 3; i++)
            o[i] = clip((v[i] * U14) / n, -U14, U14);
        return 1'b1;
    endfunction

    function automatic longint dot_q14(input longint a[3], input longint b[3]);
        return clip(fshift(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], 14), -U14, U14);
    endfunction

    function automatic longint power_q14(input longint b, input logic [7:0] e);
        longint r;
        r = U14;
        for (int i = 0; i < EB; i++)
        begin
            if (e[i])
                r = (r * b) >>> 14;
            b = (b * b) >>> 14;
        end
        return r;
    endfunction

    function automatic out_item_t shade(input in_item_t it);
        out_item_t o;
        longint d[3], a[3], nr[3], vr[3];
        longint dn[3], an[3], nn[3], vn[3], l[3], rr[3], rn[3];
        longint nl, rv, spec, wgt;
        logic [63:0] c;
        o = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i]  = comp(it.surface_point, i) - comp(lt_pos, i);
            a[i]  = comp(lt_axis, i);
            nr[i] = comp(it.surface_normal, i);
            vr[i] = comp(it.view_direction, i);
        end
        if (!to_unit(d, dn) || !to_unit(a, an) || !to_unit(nr, nn) || !to_unit(vr, vn))
            return o;
        if (dot_q14(dn, an) < longint'(lt_cut))
            return o;
        for (int i = 0; i < 3; i++)
            l[i] = -dn[i];
        nl = dot_q14(nn, l);
        for (int i = 0; i < 3; i++)
            rr[i] = fshift(2 * nl * nn[i], 14) - l[i];
        rv = to_unit(rr, rn) ? dot_q14(rn, vn) : 0;
        if (rv < 0)
            rv = 0;
        spec = power_q14(rv, it.shininess_exp);
        wgt = (nl < 0 ? -nl : nl) + spec;
        for (int i = 0; i < 3; i++)
        begin
            c = (64'(it.diffuse_coeff[16*i +: 16]) * 64'(lt_int[16*i +: 16])
                 * 64'(wgt)) >> 29;
            if (c > 64'hFFFF)
                c = 64'hFFFF;
            if (i == 0) o.red_out = c[15:0];
            else if (i == 1) o.green_out = c[15:0];
            else o.blue_out = c[15:0];
        end
        o.in_cone = 1'b1;
        return o;
    endfunction

    // Driver: one transfer per accepted edge, random idle cycles except in the quiet phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            if (start && !busy)
                shade_q.push_back(shade(item));
            if (start && busy)
                ;
            else if (pending_q.size() > 0 && !hold_send
                     && (quiet_run || $urandom_range(99) >= 9))
            begin
                start <= 1'b1;
                item  <= pending_q.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (shade_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer %p", result);
            end
            else
            begin
                out_item_t e;
                e = shade_q.pop_front();
                if (e.red_out !== result.red_out || e.green_out !== result.green_out
                    || e.blue_out !== result.blue_out || e.in_cone !== result.in_cone)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", e, result);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LIGHT_POSITION:  lt_pos  = val[47:0];
            REG_LIGHT_AXIS:      lt_axis = val[47:0];
            REG_CUTOFF_COSINE:   lt_cut  = val[15:0];
            default:             lt_int  = val[47:0];
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || start || shade_q.size() > 0)
            @(posedge clk);
        repeat (LAT + 10) @(posedge clk);
    endtask

    function automatic logic [47:0] rvec(input int mag);
        logic [47:0] v;
        for (int i = 0; i < 3; i++)
            v[16*i +: 16] = 16'($urandom_range(2 * mag) - mag);
        return v;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        int m;
        m = ($urandom_range(3) == 0) ? 32767 : 2048;
        it.surface_point  = ($urandom_range(9) == 0)
                            ? 48'((48'($urandom) << $urandom_range(16))
                                  ^ {$urandom, $urandom})
                            : rvec(m);
        it.surface_normal = ($urandom_range(29) == 0) ? 48'd0 : rvec(m);
        it.view_direction = ($urandom_range(29) == 0) ? 48'd0 : rvec(m);
        it.diffuse_coeff  = {16'($urandom), 16'($urandom), 16'($urandom)};
        it.shininess_exp  = ($urandom_range(1) == 0) ? 8'($urandom_range(16)) : 8'($urandom);
        return it;
    endfunction

    task automatic rand_phase(input int n);
        for (int i = 0; i < n; i++)
            pending_q.push_back(rand_item());
    endtask

    initial
    begin
        in_item_t it;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        lt_pos = '0;
        lt_axis = '0;
        lt_cut = '0;
        lt_int = '0;
        mismatches = 0;
        cycles = 0;
        quiet_run = 1'b0;
        hold_send = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: zero axis gives black.
        it = '{48'h0001_0002_0003, 48'h0100_0000_0000, 48'h0000_0000_FF00,
               48'hFFFF_FFFF_FFFF, 8'd5};
        pending_q.push_back(it);
        drain();

        reg_write(REG_LIGHT_POSITION, 64'h0400_0000_0000);
        reg_write(REG_LIGHT_AXIS, 64'hFC00_0000_0000);
        reg_write(REG_CUTOFF_COSINE, 64'h0000_0000_0000_3000);
        reg_write(REG_LIGHT_INTENSITY, 64'hFFFF_FFFF_FFFF);
        pending_q.push_back('{48'h0, 48'h0100_0000_0000, 48'h0100_0000_0000,
                              48'hFFFF_FFFF_FFFF, 8'd0});
        pending_q.push_back('{48'h0, 48'h0100_0000_0000, 48'hFF00_0000_0000,
                              48'h8000_8000_8000, 8'd255});
        pending_q.push_back('{48'h0400_0000_0000, 48'h0100_0000_0000,
                              48'h0100_0000_0000, 48'hFFFF_FFFF_FFFF, 8'd3});
        pending_q.push_back('{48'h0, 48'h0, 48'h0100_0000_0000, 48'hFFFF_FFFF_FFFF, 8'd1});
        pending_q.push_back('{48'h0, 48'h0100_0000_0000, 48'h0, 48'hFFFF_FFFF_FFFF, 8'd1});
        pending_q.push_back('{48'h0, 48'hFF00_0000_0000, 48'h0100_0100_0000,
                              48'h7FFF_0001_FFFF, 8'd128});
        pending_q.push_back('{48'h0000_0000_0400, 48'h0100_0000_0000,
                              48'h0100_0000_0000, 48'hFFFF_FFFF_FFFF, 8'd2});
        pending_q.push_back('{48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
                              48'h8000_8000_8000, 48'hFFFF_FFFF_FFFF, 8'd1});
        pending_q.push_back('{48'h7FFF_7FFF_7FFF, 48'h8000_7FFF_8000,
                              48'h7FFF_8000_7FFF, 48'h0000_0000_0000, 8'd64});
        pending_q.push_back('{48'h0200_0000_0000, 48'h0000_0100_0000,
                              48'h0000_0100_0000, 48'hFFFF_FFFF_FFFF, 8'd7});
        drain();

        reg_write(REG_CUTOFF_COSINE, 64'h0000_0000_0000_C000);
        reg_write(REG_LIGHT_POSITION, {16'h0, 48'h7FFF_8000_7FFF});
        reg_write(REG_LIGHT_AXIS, {16'h0, 48'h0000_0000_0000});
        pending_q.push_back('{48'h0, 48'h0100_0000_0000, 48'h0100_0000_0000,
                              48'hFFFF_FFFF_FFFF, 8'd1});
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            reg_write(REG_LIGHT_POSITION, {16'h0, rvec(ph == 5 ? 32767 : 2048)});
            reg_write(REG_LIGHT_AXIS, {16'h0, rvec(ph == 4 ? 32767 : 2048)});
            case (ph)
                0: reg_write(REG_CUTOFF_COSINE, 64'(16'hC000));
                1: reg_write(REG_CUTOFF_COSINE, 64'(16'h4000));
                2: reg_write(REG_CUTOFF_COSINE, 64'(16'h8000));
                3: reg_write(REG_CUTOFF_COSINE, 64'(16'h7FFF));
                default: reg_write(REG_CUTOFF_COSINE, 64'(16'($urandom_range(32768) - 16384)));
            endcase
            reg_write(REG_LIGHT_INTENSITY, ph == 1 ? 64'h0000_FFFF_FFFF_FFFF
                      : {16'h0, 16'($urandom), 16'($urandom), 16'($urandom)});
            quiet_run = (ph == 2);
            rand_phase(NRAND / 6);
            if (ph == 3)
            begin
                while (pending_q.size() > NRAND / 12)
                    @(posedge clk);
                hold_send = 1'b1;
                while (start || shade_q.size() > 0)
                    @(posedge clk);
                hold_send = 1'b0;
            end
            drain();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
